[src/bspc_pkg.sv]
// Shared constants, codes and the percentage table of the sector PWM compare block.
`default_nettype none

package bspc_pkg;

  // Default geometry of one electrical revolution.
  localparam int ELEC_REV_COUNTS = 289;
  localparam int SECTOR_COUNTS   = 48;

  // Field widths.
  localparam int ENC_W     = 11;
  localparam int TORQUE_W  = 7;
  localparam int ADV_W     = 9;
  localparam int MID_W     = 16;
  localparam int GAIN_W    = 10;
  localparam int CMP_W     = 16;
  localparam int ANGLE_O_W = 9;
  localparam int INSEC_O_W = 6;

  // Torque times gain fits in this many bits.
  localparam int TP_W = TORQUE_W + GAIN_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_ADVANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MIDPOINT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_GAIN = 2'd2;

  localparam logic [ADV_W-1:0]  RST_PHASE_ADVANCE  = 9'd72;
  localparam logic [MID_W-1:0]  RST_PWM_MIDPOINT   = 16'd400;
  localparam logic [GAIN_W-1:0] RST_AMPLITUDE_GAIN = 10'd346;

  // Sector codes: quotient of applied angle by sector size.
  localparam int SECTOR_NUM = 6;
  localparam int SECT_W     = 3;
  localparam logic [SECT_W-1:0] SECT_1 = 3'd0;
  localparam logic [SECT_W-1:0] SECT_2 = 3'd1;
  localparam logic [SECT_W-1:0] SECT_3 = 3'd2;
  localparam logic [SECT_W-1:0] SECT_4 = 3'd3;
  localparam logic [SECT_W-1:0] SECT_5 = 3'd4;
  localparam logic [SECT_W-1:0] SECT_6 = 3'd5;

  // Percentage table.
  localparam int PCT_LEN   = 48;
  localparam int PCT_IDX_W = 6;
  localparam int PCT_W     = 7;
  localparam int PCT_DIV   = 100;

  // Interpolation math: (hi - lo) is a 17-bit signed span, times percent
  // gives a 24-bit signed product, magnitude fits 23 bits.
  localparam int SPAN_W = CMP_W + 1;
  localparam int PROD_W = 24;
  localparam int MAG_W  = 23;

  // A negative 32-bit product -k divides as 2^32/100 - floor((k + bias)/100).
  localparam longint unsigned WRAP_Q = (64'd1 << 32) / PCT_DIV;
  localparam logic [CMP_W-1:0] WRAP_Q16 = CMP_W'(WRAP_Q);
  localparam int NEG_BIAS = PCT_DIV - 1 - int'((64'd1 << 32) % PCT_DIV);

  function automatic logic [PCT_W-1:0] pct_lookup(input logic [PCT_IDX_W-1:0] idx);
    logic [PCT_W-1:0] pct;
    case (idx)
      6'd0:  pct = 7'd100;
      6'd1:  pct = 7'd98;
      6'd2:  pct = 7'd96;
      6'd3:  pct = 7'd94;
      6'd4:  pct = 7'd91;
      6'd5:  pct = 7'd89;
      6'd6:  pct = 7'd87;
      6'd7:  pct = 7'd85;
      6'd8:  pct = 7'd83;
      6'd9:  pct = 7'd81;
      6'd10: pct = 7'd79;
      6'd11: pct = 7'd77;
      6'd12: pct = 7'd74;
      6'd13: pct = 7'd72;
      6'd14: pct = 7'd70;
      6'd15: pct = 7'd68;
      6'd16: pct = 7'd66;
      6'd17: pct = 7'd64;
      6'd18: pct = 7'd62;
      6'd19: pct = 7'd60;
      6'd20: pct = 7'd57;
      6'd21: pct = 7'd55;
      6'd22: pct = 7'd53;
      6'd23: pct = 7'd51;
      6'd24: pct = 7'd49;
      6'd25: pct = 7'd47;
      6'd26: pct = 7'd45;
      6'd27: pct = 7'd43;
      6'd28: pct = 7'd40;
      6'd29: pct = 7'd38;
      6'd30: pct = 7'd36;
      6'd31: pct = 7'd34;
      6'd32: pct = 7'd32;
      6'd33: pct = 7'd30;
      6'd34: pct = 7'd28;
      6'd35: pct = 7'd26;
      6'd36: pct = 7'd23;
      6'd37: pct = 7'd21;
      6'd38: pct = 7'd19;
      6'd39: pct = 7'd17;
      6'd40: pct = 7'd15;
      6'd41: pct = 7'd13;
      6'd42: pct = 7'd11;
      6'd43: pct = 7'd9;
      6'd44: pct = 7'd6;
      6'd45: pct = 7'd4;
      6'd46: pct = 7'd2;
      default: pct = 7'd0;
    endcase
    return pct;
  endfunction

endpackage

`default_nettype wire

[src/bspc_cdiv.sv]
// Two-stage divide by a constant: reciprocal multiply, then remainder.
`default_nettype none

module bspc_cdiv #(
  parameter int N = 11,
  parameter int D = 100
) (
  input  wire logic                         clk_i,
  input  wire logic [N-1:0]                 x_i,
  output logic      [N-1:0]                 q_o,
  output logic      [((D > 1) ? $clog2(D) : 1)-1:0] r_o
);

  localparam int RW = (D > 1) ? $clog2(D) : 1;
  localparam int L  = $clog2(D);
  localparam int SH = N + L;
  localparam longint unsigned MUL = ((longint'(1) << SH) + D - 1) / D;
  localparam logic [N:0] MUL_C = (N + 1)'(MUL);
  localparam logic [N:0] D_C   = (N + 1)'(D);

  logic [2*N:0]   prod_d, prod_q;
  logic [N-1:0]   x_a_q, x_b_q;
  logic [N-1:0]   quo_d, quo_q;
  logic [N-1:0]   qd_d, qd_q;
  logic [2*N:0]   qd_full;

  assign prod_d = {{N{1'b0}}, x_i} * {{N{1'b0}}, MUL_C};
  assign quo_d  = N'(prod_q >> SH);
  assign qd_full = {{(N + 1){1'b0}}, quo_d} * {{N{1'b0}}, D_C};
  assign qd_d   = N'(qd_full);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    x_a_q  <= x_i;
    quo_q  <= quo_d;
    qd_q   <= qd_d;
    x_b_q  <= x_a_q;
  end

  assign q_o = quo_q;
  assign r_o = RW'(x_b_q - qd_q);

endmodule

`default_nettype wire

[src/bldc_sector_pwm_compare_top.sv]
// Top level of the six-sector PWM compare generator.
//
// Each word (encoder count and torque percent) taken on start gives one
// result word, marked by a one-cycle done_o strobe. A new word can be
// taken every cycle: the datapath is a twelve-stage pipeline with no
// feedback, so busy stays low and throughput is one word per clock.
// The latency is set by three of the four constant dividers (two stages
// each), which sit in series with the add, table and multiply stages; the
// swing divider runs beside the revolution divider and adds nothing.
// Results cannot be held off by the receiver and are gone after their strobe
// cycle. Configuration (phase advance, PWM midpoint, amplitude gain) is
// written through a plain write port and is read live by the pipeline, so
// write it only while no word is in flight. Writes to an index past the
// register list are dropped. Applied angle past the sixth sector (angle 288
// at default geometry, or a large advance) drives all three compares to the
// midpoint.
`default_nettype none

module bldc_sector_pwm_compare_top #(
  parameter int ELEC_REV_COUNTS = bspc_pkg::ELEC_REV_COUNTS,
  parameter int SECTOR_COUNTS   = bspc_pkg::SECTOR_COUNTS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [bspc_pkg::ENC_W-1:0]         encoder_count_i,
  input  wire logic [bspc_pkg::TORQUE_W-1:0]      torque_percent_i,
  // result channel
  output logic                                    done_o,
  output logic      [bspc_pkg::CMP_W-1:0]         phase_u_compare_o,
  output logic      [bspc_pkg::CMP_W-1:0]         phase_v_compare_o,
  output logic      [bspc_pkg::CMP_W-1:0]         phase_w_compare_o,
  output logic      [bspc_pkg::ANGLE_O_W-1:0]     electrical_angle_o,
  output logic      [bspc_pkg::ANGLE_O_W-1:0]     applied_angle_o,
  output logic      [bspc_pkg::INSEC_O_W-1:0]     angle_in_sector_o,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [bspc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bspc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  // Pipeline depth from accepted word to result strobe.
  localparam int LAT = 12;

  // Electrical angle width, applied angle width (sum of angle and any
  // 9-bit advance), and angle-in-sector width.
  localparam int REV_W = $clog2(ELEC_REV_COUNTS);
  localparam int APP_W = $clog2(ELEC_REV_COUNTS + 511);
  localparam int ANG_W = (SECTOR_COUNTS > 1) ? $clog2(SECTOR_COUNTS) : 1;
  localparam logic [APP_W-1:0] REV_C = APP_W'(ELEC_REV_COUNTS);

  localparam int CMP_W = bspc_pkg::CMP_W;
  localparam int PRM_W = $clog2(bspc_pkg::PCT_DIV);

  typedef struct packed {
    logic [REV_W-1:0] elec;
    logic [APP_W-1:0] app;
    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] lo;
  } mid_t;

  typedef struct packed {
    mid_t                          base;
    logic [ANG_W-1:0]              angle;
    logic [bspc_pkg::SECT_W-1:0]   code;
    logic                          inr;    // sector one to six
  } late_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [bspc_pkg::ADV_W-1:0]  adv_q;
  logic [bspc_pkg::MID_W-1:0]  mid_q;
  logic [bspc_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv_q  <= bspc_pkg::RST_PHASE_ADVANCE;
      mid_q  <= bspc_pkg::RST_PWM_MIDPOINT;
      gain_q <= bspc_pkg::RST_AMPLITUDE_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bspc_pkg::CFG_PHASE_ADVANCE:  adv_q  <= cfg_wdata_i[bspc_pkg::ADV_W-1:0];
        bspc_pkg::CFG_PWM_MIDPOINT:   mid_q  <= cfg_wdata_i[bspc_pkg::MID_W-1:0];
        bspc_pkg::CFG_AMPLITUDE_GAIN: gain_q <= cfg_wdata_i[bspc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Valid line: the pipeline never stalls, so it always has room.
  // ---------------------------------------------------------------------
  logic           accept;
  logic [LAT:1]   vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:1], accept};
    end
  end

  assign done_o = vld_q[LAT];

  // ---------------------------------------------------------------------
  // Stages 1-2: encoder count mod revolution; torque times gain.
  // ---------------------------------------------------------------------
  logic [bspc_pkg::ENC_W-1:0] rev_q_unused;
  logic [REV_W-1:0]           rev_r;
  logic [bspc_pkg::TP_W-1:0]  s1_tp_q;

  bspc_cdiv #(.N(bspc_pkg::ENC_W), .D(ELEC_REV_COUNTS)) u_div_rev (
    .clk_i (clk_i),
    .x_i   (encoder_count_i),
    .q_o   (rev_q_unused),
    .r_o   (rev_r)
  );

  always_ff @(posedge clk_i) begin
    s1_tp_q <= bspc_pkg::TP_W'(torque_percent_i) * bspc_pkg::TP_W'(gain_q);
  end

  // Swing = torque * gain / 100, out at stage 3.
  logic [bspc_pkg::TP_W-1:0] swing;
  logic [PRM_W-1:0]          swing_r_unused;

  bspc_cdiv #(.N(bspc_pkg::TP_W), .D(bspc_pkg::PCT_DIV)) u_div_swing (
    .clk_i (clk_i),
    .x_i   (s1_tp_q),
    .q_o   (swing),
    .r_o   (swing_r_unused)
  );

  // ---------------------------------------------------------------------
  // Stage 3: electrical angle.  Stage 4: advance, single wrap, hi/lo.
  // ---------------------------------------------------------------------
  logic [REV_W-1:0] s3_elec_q;
  logic [APP_W-1:0] app_sum, app_d;
  mid_t             s4_q;

  always_ff @(posedge clk_i) begin
    s3_elec_q <= rev_r;
  end

  assign app_sum = APP_W'(s3_elec_q) + APP_W'(adv_q);
  assign app_d   = (app_sum >= REV_C) ? app_sum - REV_C : app_sum;

  always_ff @(posedge clk_i) begin
    s4_q.elec <= s3_elec_q;
    s4_q.app  <= app_d;
    s4_q.hi   <= mid_q + CMP_W'(swing);
    s4_q.lo   <= mid_q - CMP_W'(swing);
  end

  // ---------------------------------------------------------------------
  // Stages 5-6: sector and angle within it.
  // ---------------------------------------------------------------------
  logic [APP_W-1:0] sec_q;
  logic [ANG_W-1:0] sec_r;
  mid_t             mid_line_q [5:6];

  bspc_cdiv #(.N(APP_W), .D(SECTOR_COUNTS)) u_div_sec (
    .clk_i (clk_i),
    .x_i   (s4_q.app),
    .q_o   (sec_q),
    .r_o   (sec_r)
  );

  always_ff @(posedge clk_i) begin
    mid_line_q[5] <= s4_q;
    mid_line_q[6] <= mid_line_q[5];
  end

  // ---------------------------------------------------------------------
  // Stage 7: table lookup (clamped to the last entry) and span.
  // ---------------------------------------------------------------------
  logic [bspc_pkg::PCT_IDX_W-1:0] pct_idx;
  late_t                          late_d;
  late_t                          late_q [7:11];
  logic [bspc_pkg::PCT_W-1:0]     s7_pct_q;
  logic signed [bspc_pkg::SPAN_W-1:0] s7_span_q;

  always_comb begin
    if (32'(sec_r) < 32'(bspc_pkg::PCT_LEN)) begin
      pct_idx = bspc_pkg::PCT_IDX_W'(sec_r);
    end else begin
      pct_idx = bspc_pkg::PCT_IDX_W'(bspc_pkg::PCT_LEN - 1);
    end
    late_d.base  = mid_line_q[6];
    late_d.angle = sec_r;
    late_d.code  = bspc_pkg::SECT_W'(sec_q);
    late_d.inr   = (32'(sec_q) < 32'(bspc_pkg::SECTOR_NUM));
  end

  always_ff @(posedge clk_i) begin
    late_q[7]  <= late_d;
    late_q[8]  <= late_q[7];
    late_q[9]  <= late_q[8];
    late_q[10] <= late_q[9];
    late_q[11] <= late_q[10];
    s7_pct_q   <= bspc_pkg::pct_lookup(pct_idx);
    s7_span_q  <= $signed({1'b0, mid_line_q[6].hi}) - $signed({1'b0, mid_line_q[6].lo});
  end

  // ---------------------------------------------------------------------
  // Stage 8: span times percent.  Stage 9: magnitude for unsigned divide.
  // ---------------------------------------------------------------------
  logic signed [bspc_pkg::PROD_W-1:0] s8_prod_q;
  logic                               s9_neg_q, s10_neg_q, s11_neg_q;
  logic [bspc_pkg::MAG_W-1:0]         s9_mag_q;
  logic [bspc_pkg::MAG_W-1:0]         p_quo;
  logic [PRM_W-1:0]                   pct_r_unused;

  always_ff @(posedge clk_i) begin
    s8_prod_q <= bspc_pkg::PROD_W'(s7_span_q) *
                 bspc_pkg::PROD_W'($signed({1'b0, s7_pct_q}));
    s9_neg_q  <= s8_prod_q[bspc_pkg::PROD_W-1];
    // negative product -k wraps in 32 bits; divide k + bias instead
    s9_mag_q  <= s8_prod_q[bspc_pkg::PROD_W-1]
               ? bspc_pkg::MAG_W'(-s8_prod_q + bspc_pkg::PROD_W'(bspc_pkg::NEG_BIAS))
               : bspc_pkg::MAG_W'(s8_prod_q);
    s10_neg_q <= s9_neg_q;
    s11_neg_q <= s10_neg_q;
  end

  bspc_cdiv #(.N(bspc_pkg::MAG_W), .D(bspc_pkg::PCT_DIV)) u_div_pct (
    .clk_i (clk_i),
    .x_i   (s9_mag_q),
    .q_o   (p_quo),
    .r_o   (pct_r_unused)
  );

  // ---------------------------------------------------------------------
  // Stage 11 -> 12: third phase and phase assignment.
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] p16, third_fall, third_rise;
  logic [CMP_W-1:0] u_d, v_d, w_d;
  logic [CMP_W-1:0] hi11, lo11;

  assign hi11 = late_q[11].base.hi;
  assign lo11 = late_q[11].base.lo;
  assign p16  = s11_neg_q ? bspc_pkg::WRAP_Q16 - CMP_W'(p_quo) : CMP_W'(p_quo);
  assign third_fall = hi11 - p16;
  assign third_rise = p16 + lo11;

  always_comb begin
    u_d = mid_q;
    v_d = mid_q;
    w_d = mid_q;
    if (late_q[11].inr) begin
      unique case (late_q[11].code)
        bspc_pkg::SECT_1: begin u_d = hi11;       w_d = lo11; v_d = third_fall; end
        bspc_pkg::SECT_2: begin v_d = hi11;       w_d = lo11; u_d = third_rise; end
        bspc_pkg::SECT_3: begin v_d = hi11;       u_d = lo11; w_d = third_fall; end
        bspc_pkg::SECT_4: begin w_d = hi11;       u_d = lo11; v_d = third_rise; end
        bspc_pkg::SECT_5: begin w_d = hi11;       v_d = lo11; u_d = third_fall; end
        bspc_pkg::SECT_6: begin u_d = hi11;       v_d = lo11; w_d = third_rise; end
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0]               u_q, v_q, w_q;
  logic [bspc_pkg::ANGLE_O_W-1:0] elec_o_q, app_o_q;
  logic [bspc_pkg::INSEC_O_W-1:0] ang_o_q;

  always_ff @(posedge clk_i) begin
    u_q      <= u_d;
    v_q      <= v_d;
    w_q      <= w_d;
    elec_o_q <= bspc_pkg::ANGLE_O_W'(late_q[11].base.elec);
    app_o_q  <= bspc_pkg::ANGLE_O_W'(late_q[11].base.app);
    ang_o_q  <= bspc_pkg::INSEC_O_W'(late_q[11].angle);
  end

  assign phase_u_compare_o  = u_q;
  assign phase_v_compare_o  = v_q;
  assign phase_w_compare_o  = w_q;
  assign electrical_angle_o = elec_o_q;
  assign applied_angle_o    = app_o_q;
  assign angle_in_sector_o  = ang_o_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // Every result strobe traces back to a word taken on start.
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result strobe without matching start");

  // Past the sixth sector all phases sit at the midpoint.
  a_out_of_range_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && !late_q[11].inr) |=>
      (phase_u_compare_o == mid_q && phase_v_compare_o == mid_q &&
       phase_w_compare_o == mid_q))
    else $error("out-of-range sector did not drive midpoint");

  // Electrical angle stays below one revolution.
  a_elec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((ELEC_REV_COUNTS > 512) ||
                (32'(electrical_angle_o) < 32'(ELEC_REV_COUNTS))))
    else $error("electrical angle not reduced");

  // Angle within sector stays below the sector size.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((SECTOR_COUNTS > 64) ||
                (32'(angle_in_sector_o) < 32'(SECTOR_COUNTS))))
    else $error("angle in sector out of range");

endmodule

`default_nettype wire
